// File: src/slte_pkg.sv
package slte_pkg;

    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_NEURONS = 16;

    localparam logic [1:0] FUNC_INPUT  = 2'd0;
    localparam logic [1:0] FUNC_ERROR  = 2'd1;
    localparam logic [1:0] FUNC_WWRITE = 2'd2;
    localparam logic [1:0] FUNC_WREAD  = 2'd3;

    localparam logic [1:0] KIND_ACT   = 2'd0;
    localparam logic [1:0] KIND_ERR   = 2'd1;
    localparam logic [1:0] KIND_WREAD = 2'd2;

    localparam logic [1:0] REG_INPUTS  = 2'd0;
    localparam logic [1:0] REG_NEURONS = 2'd1;
    localparam logic [1:0] REG_RATE    = 2'd2;
    localparam logic [1:0] REG_MODE    = 2'd3;

    localparam logic [4:0]  RST_INPUTS  = 5'd16;
    localparam logic [4:0]  RST_NEURONS = 5'd16;
    localparam logic [15:0] RST_RATE    = 16'd6554;
    localparam logic        RST_MODE    = 1'b0;

    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
        logic [3:0] nrn;
        logic [3:0] inp;
        logic       first;
        logic       emit;
        logic       last;
        logic       zero;
    } t_issue;

    typedef struct packed {
        logic              vld;
        logic [1:0]        kind;
        logic [3:0]        idx;
        logic signed [15:0] value;
        logic              last;
    } t_result;

    typedef struct packed {
        logic        we;
        logic [3:0]  idx;
        logic [11:0] value;
    } t_actwr;

    function automatic logic signed [15:0] f_sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [11:0] f_sig_point(input logic [5:0] k);
        logic [11:0] r;
        unique case (k)
            6'd0:  r = 12'd1;
            6'd1:  r = 12'd2;
            6'd2:  r = 12'd4;
            6'd3:  r = 12'd6;
            6'd4:  r = 12'd10;
            6'd5:  r = 12'd17;
            6'd6:  r = 12'd27;
            6'd7:  r = 12'd45;
            6'd8:  r = 12'd74;
            6'd9:  r = 12'd120;
            6'd10: r = 12'd194;
            6'd11: r = 12'd311;
            6'd12: r = 12'd488;
            6'd13: r = 12'd747;
            6'd14: r = 12'd1102;
            6'd15: r = 12'd1546;
            6'd16: r = 12'd2048;
            6'd17: r = 12'd2550;
            6'd18: r = 12'd2994;
            6'd19: r = 12'd3349;
            6'd20: r = 12'd3608;
            6'd21: r = 12'd3785;
            6'd22: r = 12'd3902;
            6'd23: r = 12'd3976;
            6'd24: r = 12'd4022;
            6'd25: r = 12'd4051;
            6'd26: r = 12'd4069;
            6'd27: r = 12'd4079;
            6'd28: r = 12'd4086;
            6'd29: r = 12'd4090;
            6'd30: r = 12'd4092;
            6'd31: r = 12'd4094;
            default: r = 12'd4095;
        endcase
        return r;
    endfunction

endpackage

// File: src/slte_wmem.sv
module slte_wmem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic signed [15:0]  o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic signed [15:0]  i_wr_data
);

    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

// File: src/slte_pipe.sv
module slte_pipe
    import slte_pkg::*;
#(
    parameter int MAX_INPUTS = DEF_MAX_INPUTS,
    parameter int AW         = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_issue              i_issue,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_e,
    input  logic [11:0]         i_a,
    input  logic [15:0]         i_rate,
    input  logic signed [15:0]  i_rdata,
    output logic                o_busy,
    output t_result             o_res,
    output t_actwr              o_act,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic signed [15:0]  o_wdata
);

    t_issue r_s1, r_s2, r_s3, r_s4, r_s5;

    logic signed [15:0] r_x1, r_e1;
    logic [11:0]        r_a1;

    logic signed [31:0] r_pb2;
    logic [10:0]        r_d2;
    logic signed [15:0] r_w2, r_e2, r_x2;

    logic signed [35:0] r_acc3;
    logic signed [14:0] r_t1_3;
    logic signed [15:0] r_w3, r_x3;

    logic signed [15:0] r_rv4;
    logic signed [17:0] r_t2_4;
    logic signed [15:0] r_w4;

    logic signed [15:0] r_rv5;
    logic [11:0]        r_lo5;
    logic [8:0]         r_df5;
    logic [10:0]        r_fr5;
    logic signed [17:0] r_t3_5;
    logic signed [15:0] r_w5;

    logic signed [15:0] mul_a;
    logic [24:0]        d_full;
    logic signed [27:0] t1_full;
    logic signed [30:0] t2_full;
    logic signed [34:0] t3_full;
    logic signed [15:0] rv;
    logic [15:0]        u;
    logic [5:0]         seg;
    logic [11:0]        lo, hi;
    logic [19:0]        ip_prod;
    logic [11:0]        interp;
    logic [12:0]        waddr_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else if (i_adv) begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s5 <= r_s4;
        end
    end

    always_comb begin
        mul_a   = (r_s1.kind == KIND_ACT) ? r_x1 : r_e1;
        d_full  = 25'(r_a1) * (25'd4096 - 25'(r_a1));
        t1_full = r_e2 * $signed({1'b0, r_d2});
        t2_full = r_t1_3 * r_x3;
        t3_full = r_t2_4 * $signed({1'b0, i_rate});
        if (r_s3.kind == KIND_WREAD) begin
            rv = r_s3.zero ? 16'sd0 : r_w3;
        end else begin
            rv = f_sat16(40'($signed(r_acc3[35:12])));
        end
        u   = r_rv4 ^ 16'h8000;
        seg = {1'b0, u[15:11]};
        lo  = f_sig_point(seg);
        hi  = f_sig_point(seg + 6'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1 <= i_x;
            r_e1 <= i_e;
            r_a1 <= i_a;

            r_pb2 <= mul_a * i_rdata;
            r_d2  <= d_full[22:12];
            r_w2  <= i_rdata;
            r_e2  <= r_e1;
            r_x2  <= r_x1;

            if (r_s2.vld && r_s2.kind != KIND_WREAD) begin
                r_acc3 <= r_s2.first ? 36'(r_pb2) : r_acc3 + 36'(r_pb2);
            end
            r_t1_3 <= t1_full[26:12];
            r_w3   <= r_w2;
            r_x3   <= r_x2;

            r_rv4  <= rv;
            r_t2_4 <= t2_full[29:12];
            r_w4   <= r_w3;

            r_rv5  <= r_rv4;
            r_lo5  <= lo;
            r_df5  <= 9'(hi - lo);
            r_fr5  <= u[10:0];
            r_t3_5 <= t3_full[33:16];
            r_w5   <= r_w4;
        end
    end

    always_comb begin
        ip_prod    = 20'(r_df5) * 20'(r_fr5);
        interp     = r_lo5 + 12'(ip_prod >> 11);
        waddr_full = 13'(r_s5.nrn) * 13'(MAX_INPUTS) + 13'(r_s5.inp);

        o_res.vld   = r_s5.vld && r_s5.emit;
        o_res.kind  = r_s5.kind;
        o_res.idx   = (r_s5.kind == KIND_ACT) ? r_s5.nrn : r_s5.inp;
        o_res.value = (r_s5.kind == KIND_ACT) ? $signed({4'b0, interp}) : r_rv5;
        o_res.last  = r_s5.last;

        o_act.we    = i_adv && r_s5.vld && r_s5.emit && r_s5.kind == KIND_ACT;
        o_act.idx   = r_s5.nrn;
        o_act.value = interp;

        o_we    = i_adv && r_s5.vld && r_s5.kind == KIND_ERR;
        o_waddr = waddr_full[AW-1:0];
        o_wdata = f_sat16(40'(r_w5) + 40'(r_t3_5));

        o_busy  = r_s1.vld || r_s2.vld || r_s3.vld || r_s4.vld || r_s5.vld;
    end

endmodule

// File: src/sigmoid_layer_train_engine.sv
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_func, i_neuron, i_input_pos, i_value
// output    out        o_valid / i_stall   o_out_kind, o_index, o_result_value, o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item is taken at a time. A forward or backward pass issues one weight read per
// cycle while the output is not stalled and holds the input until it has drained; each
// word passes the pipeline stages and the output register after the weight read that
// completes it. A weight read holds the input until its word leaves the pipeline; other
// items do not. Reset is synchronous and clears control, configuration and the small
// stores; the weight memory is not cleared. A stalled output word freezes the pass.
module sigmoid_layer_train_engine
    import slte_pkg::*;
#(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic [3:0]          i_neuron,
    input  logic [3:0]          i_input_pos,
    input  logic signed [15:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_out_kind,
    output logic [3:0]          o_index,
    output logic signed [15:0]  o_result_value,
    output logic                o_last,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);

    localparam int DEPTH  = MAX_NEURONS * MAX_INPUTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IN_LIM = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
    localparam int NR_LIM = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;

    logic [4:0]  r_ni_cfg, r_nn_cfg;
    logic [15:0] r_rate;
    logic        r_emode;

    logic signed [15:0] r_in  [16];
    logic signed [15:0] r_err [16];
    logic [11:0]        r_act [16];

    logic        r_run;
    logic [1:0]  r_kind;
    logic [3:0]  r_oi, r_ii;
    logic        r_rdz;

    logic        r_ovld;
    logic [1:0]  r_okind;
    logic [3:0]  r_oidx;
    logic signed [15:0] r_oval;
    logic        r_olast;

    logic [4:0]  ni, nn;
    logic        adv, in_acc, nr_ok, ip_ok;
    t_issue      issue;
    logic [12:0] iaddr_full, raddr_full;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        wr_en, item_we;
    logic signed [15:0] wr_data, rdata, err_val;

    logic          pipe_busy, pipe_we;
    t_result       res;
    t_actwr        actwr;
    logic [AW-1:0] pipe_waddr;
    logic signed [15:0] pipe_wdata;

    always_comb begin
        if (r_ni_cfg == 5'd0) begin
            ni = 5'd1;
        end else if (r_ni_cfg > 5'(IN_LIM)) begin
            ni = 5'(IN_LIM);
        end else begin
            ni = r_ni_cfg;
        end
        if (r_nn_cfg == 5'd0) begin
            nn = 5'd1;
        end else if (r_nn_cfg > 5'(NR_LIM)) begin
            nn = 5'(NR_LIM);
        end else begin
            nn = r_nn_cfg;
        end
    end

    assign adv     = !r_ovld || !i_stall;
    assign o_stall = r_run || pipe_busy;
    assign in_acc  = i_valid && !o_stall;
    assign nr_ok   = int'(i_neuron) < MAX_NEURONS;
    assign ip_ok   = int'(i_input_pos) < MAX_INPUTS;
    assign item_we = in_acc && i_func == FUNC_WWRITE && nr_ok && ip_ok;
    assign err_val = r_emode ? i_value
                   : f_sat16(40'(i_value) - 40'($signed({1'b0, r_act[i_neuron]})));

    always_comb begin
        issue       = '0;
        issue.vld   = r_run;
        issue.kind  = r_kind;
        issue.first = (r_ii == 4'd0);
        issue.zero  = r_rdz;
        unique case (r_kind)
            KIND_ACT: begin
                issue.nrn  = r_oi;
                issue.inp  = r_ii;
                issue.emit = ({1'b0, r_ii} == ni - 5'd1);
                issue.last = issue.emit && ({1'b0, r_oi} == nn - 5'd1);
            end
            KIND_ERR: begin
                issue.nrn  = r_ii;
                issue.inp  = r_oi;
                issue.emit = ({1'b0, r_ii} == nn - 5'd1);
                issue.last = issue.emit && ({1'b0, r_oi} == ni - 5'd1);
            end
            default: begin
                issue.nrn  = r_oi;
                issue.inp  = r_ii;
                issue.emit = 1'b1;
                issue.last = 1'b1;
            end
        endcase
        raddr_full = 13'(issue.nrn) * 13'(MAX_INPUTS) + 13'(issue.inp);
        rd_addr    = issue.zero ? '0 : raddr_full[AW-1:0];
        iaddr_full = 13'(i_neuron) * 13'(MAX_INPUTS) + 13'(i_input_pos);
        wr_en      = item_we || pipe_we;
        wr_addr    = item_we ? iaddr_full[AW-1:0] : pipe_waddr;
        wr_data    = item_we ? i_value : pipe_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ni_cfg <= RST_INPUTS;
            r_nn_cfg <= RST_NEURONS;
            r_rate   <= RST_RATE;
            r_emode  <= RST_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INPUTS:  r_ni_cfg <= i_cfg_data[4:0];
                REG_NEURONS: r_nn_cfg <= i_cfg_data[4:0];
                REG_RATE:    r_rate   <= i_cfg_data;
                REG_MODE:    r_emode  <= i_cfg_data[0];
                default:     r_emode  <= r_emode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_in[k]  <= '0;
                r_err[k] <= '0;
                r_act[k] <= '0;
            end
        end else begin
            if (in_acc && i_func == FUNC_INPUT && ip_ok) begin
                r_in[i_input_pos] <= i_value;
            end
            if (in_acc && i_func == FUNC_ERROR && nr_ok) begin
                r_err[i_neuron] <= err_val;
            end
            if (actwr.we) begin
                r_act[actwr.idx] <= actwr.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_kind <= KIND_ACT;
            r_oi   <= '0;
            r_ii   <= '0;
            r_rdz  <= 1'b0;
        end else if (in_acc) begin
            r_oi  <= '0;
            r_ii  <= '0;
            r_rdz <= 1'b0;
            unique case (i_func)
                FUNC_INPUT: begin
                    r_kind <= KIND_ACT;
                    r_run  <= ip_ok && ({1'b0, i_input_pos} == ni - 5'd1);
                end
                FUNC_ERROR: begin
                    r_kind <= KIND_ERR;
                    r_run  <= nr_ok && ({1'b0, i_neuron} == nn - 5'd1);
                end
                FUNC_WREAD: begin
                    r_kind <= KIND_WREAD;
                    r_run  <= 1'b1;
                    r_oi   <= i_neuron;
                    r_ii   <= i_input_pos;
                    r_rdz  <= !(nr_ok && ip_ok);
                end
                default: begin
                    r_run <= 1'b0;
                end
            endcase
        end else if (r_run && adv) begin
            if (issue.last) begin
                r_run <= 1'b0;
            end else if (issue.emit) begin
                r_ii <= '0;
                r_oi <= r_oi + 4'd1;
            end else begin
                r_ii <= r_ii + 4'd1;
            end
        end
    end

    slte_wmem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_wmem (
        .i_clk    (i_clk),
        .i_rd_en  (adv),
        .i_rd_addr(rd_addr),
        .o_rd_data(rdata),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    slte_pipe #(
        .MAX_INPUTS(MAX_INPUTS),
        .AW        (AW)
    ) u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_issue(issue),
        .i_x    (r_in[issue.inp]),
        .i_e    (r_err[issue.nrn]),
        .i_a    (r_act[issue.nrn]),
        .i_rate (r_rate),
        .i_rdata(rdata),
        .o_busy (pipe_busy),
        .o_res  (res),
        .o_act  (actwr),
        .o_we   (pipe_we),
        .o_waddr(pipe_waddr),
        .o_wdata(pipe_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.vld) begin
            r_okind <= res.kind;
            r_oidx  <= res.idx;
            r_oval  <= res.value;
            r_olast <= res.last;
        end
    end

    assign o_valid        = r_ovld;
    assign o_out_kind     = r_okind;
    assign o_index        = r_oidx;
    assign o_result_value = r_oval;
    assign o_last         = r_olast;

`ifndef ASSERT_OFF
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_we |-> !in_acc)
        else $error("weight write from the update pass collides with an item");

    a_act_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_okind == KIND_ACT) |-> ({1'b0, r_oidx} < nn))
        else $error("activation index beyond neurons in use");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_okind == KIND_WREAD) |-> r_olast)
        else $error("weight readback word without last");
`endif

endmodule

// File: verif/tb.sv
module tb
    import slte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  SETTLE      = 700;
    localparam int  WORDS       = 180;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        last;
    } t_layer_word;

    class layer_scoreboard;
        int          in_vec[16];
        int          act_vec[16];
        int          err_vec[16];
        int          weights[256];
        int          in_count;
        int          nrn_count;
        int          rate;
        int          mode;
        int          mismatches;
        t_layer_word pending[$];
        int          sig_points[33] = '{
            1, 2, 4, 6, 10, 17, 27, 45, 74, 120, 194, 311, 488, 747, 1102, 1546,
            2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022, 4051, 4069, 4079,
            4086, 4090, 4092, 4094, 4095};

        function new();
            in_count  = RST_INPUTS;
            nrn_count = RST_NEURONS;
            rate      = RST_RATE;
            mode      = RST_MODE;
            foreach (in_vec[k]) in_vec[k] = 0;
            foreach (act_vec[k]) act_vec[k] = 0;
            foreach (err_vec[k]) err_vec[k] = 0;
            foreach (weights[k]) weights[k] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_INPUTS:  in_count  = data[4:0];
                REG_NEURONS: nrn_count = data[4:0];
                REG_RATE:    rate      = data;
                REG_MODE:    mode      = data[0];
            endcase
        endfunction

        function int clamp_count(int c);
            return (c < 1) ? 1 : ((c > 16) ? 16 : c);
        endfunction

        function int sat16(longint v);
            return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : int'(v));
        endfunction

        function int sigmoid(int s);
            int u;
            int i;
            int f;
            u = s + 32768;
            i = (u >> 11) & 31;
            f = u & 2047;
            return sig_points[i] + (((sig_points[i + 1] - sig_points[i]) * f) >> 11);
        endfunction

        function void push(logic [1:0] kind, int idx, int val, bit last);
            t_layer_word w;
            w.kind = kind;
            w.idx  = idx;
            w.val  = val[15:0];
            w.last = last;
            pending = {pending, w};
        endfunction

        function void note_input(logic [1:0] func, int nr, int ip, int val);
            int     ni;
            int     nn;
            longint acc;
            longint a;
            longint d;
            longint t1;
            longint t2;
            longint t3;
            ni = clamp_count(in_count);
            nn = clamp_count(nrn_count);
            case (func)
                FUNC_INPUT: begin
                    in_vec[ip] = val;
                    if (ip == ni - 1) begin
                        for (int i = 0; i < nn; i++) begin
                            acc = 0;
                            for (int j = 0; j < ni; j++)
                                acc += longint'(in_vec[j]) * weights[i * 16 + j];
                            act_vec[i] = sigmoid(sat16(acc >>> 12));
                            push(KIND_ACT, i, act_vec[i], i == nn - 1);
                        end
                    end
                end
                FUNC_ERROR: begin
                    err_vec[nr] = (mode == 0) ? sat16(longint'(val) - act_vec[nr]) : val;
                    if (nr == nn - 1) begin
                        for (int j = 0; j < ni; j++) begin
                            acc = 0;
                            for (int i = 0; i < nn; i++)
                                acc += longint'(err_vec[i]) * weights[i * 16 + j];
                            push(KIND_ERR, j, sat16(acc >>> 12), j == ni - 1);
                        end
                        for (int i = 0; i < nn; i++) begin
                            a  = act_vec[i];
                            d  = (a * (4096 - a)) >>> 12;
                            t1 = (longint'(err_vec[i]) * d) >>> 12;
                            for (int j = 0; j < ni; j++) begin
                                t2 = (t1 * in_vec[j]) >>> 12;
                                t3 = (t2 * rate) >>> 16;
                                weights[i * 16 + j] = sat16(weights[i * 16 + j] + t3);
                            end
                        end
                    end
                end
                FUNC_WWRITE: weights[nr * 16 + ip] = val;
                default: push(KIND_WREAD, ip, weights[nr * 16 + ip], 1'b1);
            endcase
        endfunction

        function void check(logic [1:0] kind, logic [3:0] idx, logic [15:0] val, logic last);
            t_layer_word w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word kind=%0d idx=%0d val=%0d last=%0d",
                             kind, idx, $signed(val), last);
                return;
            end
            w = pending.pop_front();
            if (w.kind !== kind || w.idx !== idx || w.val !== val || w.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             w.kind, w.idx, $signed(w.val), w.last,
                             kind, idx, $signed(val), last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [3:0]         i_neuron;
    logic [3:0]         i_input_pos;
    logic signed [15:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_out_kind;
    logic [3:0]         o_index;
    logic signed [15:0] o_result_value;
    logic               o_last;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    layer_scoreboard layer_sb;
    bit              quiet;
    int              cycles;
    int              sent;

    sigmoid_layer_train_engine uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall)
            layer_sb.check(o_out_kind, o_index, o_result_value, o_last);
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, 8192) - 4096;
    endfunction

    task automatic send(logic [1:0] func, logic [3:0] nr, logic [3:0] ip, logic [15:0] val);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_func      = func;
        i_neuron    = nr;
        i_input_pos = ip;
        i_value     = val;
        do @(posedge i_clk); while (o_stall);
        layer_sb.note_input(func, nr, ip, $signed(val));
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (layer_sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        layer_sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(int ni, int nn, int rate, int mode);
        drain();
        write_reg(REG_INPUTS, ni);
        write_reg(REG_NEURONS, nn);
        write_reg(REG_RATE, rate);
        write_reg(REG_MODE, mode);
    endtask

    task automatic train_sequence();
        int ni;
        int nn;
        ni = layer_sb.clamp_count(layer_sb.in_count);
        nn = layer_sb.clamp_count(layer_sb.nrn_count);
        for (int j = 0; j < ni; j++)
            send(FUNC_INPUT, $urandom_range(0, 15), j, pick_value());
        if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < nn; i++)
                send(FUNC_ERROR, i, $urandom_range(0, 15),
                     layer_sb.mode ? pick_value() : $urandom_range(0, 4096));
    endtask

    initial begin
        int ni_set[6];
        int nn_set[6];
        int stop_at;
        ni_set      = '{2, 0, 31, 3, 1, 4};
        nn_set      = '{3, 0, 31, 2, 4, 1};
        layer_sb    = new();
        quiet       = 1'b0;
        sent        = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_INPUT;
        i_neuron    = '0;
        i_input_pos = '0;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_INPUTS;
        i_cfg_data  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < 16; n++)
            for (int j = 0; j < 16; j++)
                send(FUNC_WWRITE, n, j, (n == j) ? 16'h7FFF : ((n == 15 - j) ? 16'h8000
                     : pick_value()));

        send(FUNC_WREAD, 15, 15, 16'h0000);
        send(FUNC_WREAD, 0, 15, 16'hFFFF);
        send(FUNC_INPUT, 0, 0, 16'h7FFF);
        send(FUNC_INPUT, 0, 1, 16'h8000);
        send(FUNC_INPUT, 0, 15, 16'h1000);
        send(FUNC_ERROR, 3, 0, 16'h7FFF);
        send(FUNC_ERROR, 15, 0, 16'h8000);
        send(FUNC_WREAD, 3, 1, 16'h0000);
        configure(2, 2, 65535, 1);
        send(FUNC_INPUT, 0, 5, 16'h2000);
        send(FUNC_INPUT, 0, 1, 16'hF000);
        send(FUNC_ERROR, 0, 0, 16'h7FFF);
        send(FUNC_ERROR, 9, 0, 16'h1234);
        send(FUNC_ERROR, 1, 0, 16'h8000);
        send(FUNC_WREAD, 1, 1, 16'h0000);

        for (int p = 0; p < 6; p++) begin
            configure(ni_set[p], nn_set[p], (p == 1) ? 0 : ((p == 2) ? 65535
                      : $urandom_range(0, 65535)), p % 2);
            if (p == 5)
                quiet = 1'b1;
            stop_at = sent + WORDS / 6;
            while (sent < stop_at) begin
                if ($urandom_range(0, 9) < 7) begin
                    train_sequence();
                end else begin
                    send($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                         pick_value());
                end
                if (p == 3 && sent > stop_at - 20) begin
                    i_valid = 1'b0;
                    while (layer_sb.pending.size() != 0) @(negedge i_clk);
                end
            end
        end

        drain();
        if (layer_sb.mismatches == 0 && layer_sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/slte_pkg.sv
src/slte_wmem.sv
src/slte_pipe.sv
src/sigmoid_layer_train_engine.sv
verif/tb.sv
